@@ hw/rtl/olg_pkg.sv @@
// shared constants, codes and control types for the occupancy grid projector
package olg_pkg;

    localparam int GRID_SIDE_DEF = 256;
    localparam int MAX_LEVEL_DEF = 8;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int DIM_CFG_W = 9;
    localparam int Z_W = 17;
    localparam int KEY_W = 16;
    localparam int LVL_W = 5;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PAINT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] CELL_UNKNOWN = 2'd0;
    localparam logic [1:0] CELL_FREE    = 2'd1;
    localparam logic [1:0] CELL_OCC     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd5;

    localparam logic [7:0] PIX_FREE    = 8'd254;
    localparam logic [7:0] PIX_OCC     = 8'd0;
    localparam logic [7:0] PIX_UNKNOWN = 8'd205;

    typedef struct packed {
        logic load_item;
        logic pix_rd;
        logic clear_all;
        logic span_calc;
        logic row_rd;
        logic row_wr;
        logic out_load;
    } olg_cmd_t;

    typedef struct packed {
        logic span_ok;
        logic row_last;
    } olg_sts_t;

    function automatic logic [7:0] cell_to_pixel(input logic [1:0] st);
        logic [7:0] p;
        case (st)
            CELL_FREE: p = PIX_FREE;
            CELL_OCC:  p = PIX_OCC;
            default:   p = PIX_UNKNOWN;
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/olg_ctrl.sv @@
// sequencer for clear, paint and read words
module olg_ctrl
    import olg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] op,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  olg_sts_t   sts,
    output olg_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_ROW_RD,
        ST_ROW_WR,
        ST_PIX_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op)
                        OP_CLEAR:
                        begin
                            cmd.clear_all = 1'b1;
                        end
                        OP_PAINT:
                        begin
                            cmd.load_item = 1'b1;
                            state_next = ST_SPAN;
                        end
                        OP_READ:
                        begin
                            cmd.load_item = 1'b1;
                            cmd.pix_rd = 1'b1;
                            state_next = ST_PIX_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SPAN:
            begin
                cmd.span_calc = 1'b1;
                state_next = ST_ROW_RD;
            end
            ST_ROW_RD:
            begin
                if (sts.span_ok)
                begin
                    cmd.row_rd = 1'b1;
                    state_next = ST_ROW_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROW_WR:
            begin
                cmd.row_wr = 1'b1;
                state_next = sts.row_last ? ST_IDLE : ST_ROW_RD;
            end
            ST_PIX_OUT:
            begin
                // hold the answer until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.out_load | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/olg_dp.sv @@
// datapath: config registers, footprint clipping, row memory and pixel output
module olg_dp
    import olg_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [KEY_W-1:0]      leaf_x,
    input  logic [KEY_W-1:0]      leaf_y,
    input  logic [3:0]            level,
    input  logic                  occupied,
    input  logic signed [Z_W-1:0] z_center,
    input  logic [7:0]            read_col,
    input  logic [7:0]            read_row,
    input  olg_cmd_t              cmd,
    output olg_sts_t              sts,
    output logic [7:0]            pixel,
    output logic [1:0]            cell_state
);

    localparam int IDX_W = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int PT_W = IDX_W + 1;
    localparam int DIM_W = (PT_W > DIM_CFG_W) ? PT_W : DIM_CFG_W;
    localparam int SIDE_W = MAX_LEVEL + 1;
    localparam int REL_W = KEY_W + 1;
    localparam int SUM_W = ((SIDE_W + 1 > REL_W) ? SIDE_W + 1 : REL_W) + 1;
    localparam int ROW_W = 2 * GRID_SIDE;

    // configuration
    logic signed [Z_W-1:0]   min_z_reg;
    logic signed [Z_W-1:0]   max_z_reg;
    logic [KEY_W-1:0]        origin_x_reg;
    logic [KEY_W-1:0]        origin_y_reg;
    logic [DIM_CFG_W-1:0]    grid_width_reg;
    logic [DIM_CFG_W-1:0]    grid_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_z_reg <= -17'sd65536;
            max_z_reg <= 17'sd65535;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            grid_width_reg <= 9'd256;
            grid_height_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_Z:    min_z_reg <= cfg_data;
                CFG_MAX_Z:    max_z_reg <= cfg_data;
                CFG_ORIGIN_X: origin_x_reg <= cfg_data[KEY_W-1:0];
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data[KEY_W-1:0];
                CFG_WIDTH:    grid_width_reg <= cfg_data[DIM_CFG_W-1:0];
                CFG_HEIGHT:   grid_height_reg <= cfg_data[DIM_CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    // clamped grid size
    logic [DIM_W-1:0] w_clamp;
    logic [DIM_W-1:0] h_clamp;

    always_comb
    begin
        if (grid_width_reg == '0)
            w_clamp = DIM_W'(1);
        else if (DIM_W'(grid_width_reg) > DIM_W'(GRID_SIDE))
            w_clamp = DIM_W'(GRID_SIDE);
        else
            w_clamp = DIM_W'(grid_width_reg);
        if (grid_height_reg == '0)
            h_clamp = DIM_W'(1);
        else if (DIM_W'(grid_height_reg) > DIM_W'(GRID_SIDE))
            h_clamp = DIM_W'(GRID_SIDE);
        else
            h_clamp = DIM_W'(grid_height_reg);
    end

    // item registers loaded when a paint or read word is accepted
    logic signed [REL_W-1:0] rel_x_reg;
    logic signed [REL_W-1:0] rel_y_reg;
    logic [SIDE_W-1:0]       side_reg;
    logic                    occ_reg;
    logic                    paint_en_reg;
    logic                    pix_in_range_reg;
    logic [IDX_W-1:0]        pix_col_reg;

    logic [LVL_W-1:0]        lvl_eff;
    logic                    z_ok;
    logic                    pix_in_range;
    logic [DIM_W-1:0]        pix_row_full;
    logic [IDX_W-1:0]        pix_addr;

    always_comb
    begin
        if (LVL_W'(level) > LVL_W'(MAX_LEVEL))
            lvl_eff = LVL_W'(MAX_LEVEL);
        else
            lvl_eff = LVL_W'(level);
        z_ok = (z_center > min_z_reg) && (z_center < max_z_reg);
        pix_in_range = (DIM_W'(read_col) < w_clamp) && (DIM_W'(read_row) < h_clamp);
        // image rows run top down, grid rows bottom up
        pix_row_full = h_clamp - DIM_W'(1) - DIM_W'(read_row);
        pix_addr = pix_row_full[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            rel_x_reg <= $signed({1'b0, leaf_x}) - $signed({1'b0, origin_x_reg});
            rel_y_reg <= $signed({1'b0, leaf_y}) - $signed({1'b0, origin_y_reg});
            side_reg <= SIDE_W'(1) << lvl_eff;
            occ_reg <= occupied;
            paint_en_reg <= !occupied || z_ok;
            pix_in_range_reg <= pix_in_range;
            pix_col_reg <= IDX_W'(read_col);
        end
    end

    // footprint clipping to [0, size)
    logic signed [SUM_W-1:0] x_lo;
    logic signed [SUM_W-1:0] x_hi;
    logic signed [SUM_W-1:0] y_lo;
    logic signed [SUM_W-1:0] y_hi;
    logic signed [SUM_W-1:0] x_end;
    logic signed [SUM_W-1:0] y_end;
    logic signed [SUM_W-1:0] w_s;
    logic signed [SUM_W-1:0] h_s;

    always_comb
    begin
        w_s = $signed(SUM_W'(w_clamp));
        h_s = $signed(SUM_W'(h_clamp));
        x_end = SUM_W'(rel_x_reg) + $signed(SUM_W'(side_reg));
        y_end = SUM_W'(rel_y_reg) + $signed(SUM_W'(side_reg));
        x_lo = (rel_x_reg < 0) ? '0 : SUM_W'(rel_x_reg);
        y_lo = (rel_y_reg < 0) ? '0 : SUM_W'(rel_y_reg);
        x_hi = (x_end > w_s) ? w_s : x_end;
        y_hi = (y_end > h_s) ? h_s : y_end;
    end

    logic            span_ok_reg;
    logic [PT_W-1:0] x0_reg;
    logic [PT_W-1:0] x1_reg;
    logic [PT_W-1:0] y_reg;
    logic [PT_W-1:0] y1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_ok_reg <= 1'b0;
        end
        else if (cmd.span_calc)
        begin
            span_ok_reg <= paint_en_reg && (x_lo < x_hi) && (y_lo < y_hi);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.span_calc)
        begin
            x0_reg <= x_lo[PT_W-1:0];
            x1_reg <= x_hi[PT_W-1:0];
            y_reg <= y_lo[PT_W-1:0];
            y1_reg <= y_hi[PT_W-1:0];
        end
        else if (cmd.row_wr)
        begin
            y_reg <= y_reg + PT_W'(1);
        end
    end

    // row memory: one word holds a whole grid row, row valid bits stand in for clearing
    logic [ROW_W-1:0]     mem [GRID_SIDE];
    logic [GRID_SIDE-1:0] row_vld_reg;
    logic [ROW_W-1:0]     rdata_reg;
    logic                 rvld_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     row_addr;
    logic [ROW_W-1:0]     row_new;

    assign row_addr = y_reg[IDX_W-1:0];
    assign rd_addr = cmd.pix_rd ? pix_addr : row_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.pix_rd || cmd.row_rd)
        begin
            rdata_reg <= mem[rd_addr];
            rvld_reg <= row_vld_reg[rd_addr];
        end
        if (cmd.row_wr)
        begin
            mem[row_addr] <= row_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            row_vld_reg <= '0;
        end
        else if (cmd.row_wr)
        begin
            row_vld_reg[row_addr] <= 1'b1;
        end
    end

    always_comb
    begin
        logic [1:0] old_c;
        logic       hit;
        row_new = '0;
        for (int i = 0; i < GRID_SIDE; i++)
        begin
            old_c = rvld_reg ? rdata_reg[2*i +: 2] : CELL_UNKNOWN;
            hit = (PT_W'(i) >= x0_reg) && (PT_W'(i) < x1_reg);
            if (hit && occ_reg)
                row_new[2*i +: 2] = CELL_OCC;
            else if (hit && (old_c == CELL_UNKNOWN))
                row_new[2*i +: 2] = CELL_FREE;
            else
                row_new[2*i +: 2] = old_c;
        end
    end

    assign sts.span_ok = span_ok_reg;
    assign sts.row_last = ((y_reg + PT_W'(1)) == y1_reg);

    // pixel output register
    logic [1:0] pix_cell;
    logic [1:0] pix_state;
    logic [7:0] pixel_reg;
    logic [1:0] cell_state_reg;

    always_comb
    begin
        pix_cell = rdata_reg[2*pix_col_reg +: 2];
        if (pix_in_range_reg && rvld_reg && (pix_cell == CELL_FREE || pix_cell == CELL_OCC))
            pix_state = pix_cell;
        else
            pix_state = CELL_UNKNOWN;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_reg <= cell_to_pixel(pix_state);
            cell_state_reg <= pix_state;
        end
    end

    assign pixel = pixel_reg;
    assign cell_state = cell_state_reg;

endmodule

@@ hw/rtl/octree_leaf_to_occupancy_grid.sv @@
// top level of the octree leaf to occupancy grid projector
// Projects octree leaves onto a GRID_SIDE x GRID_SIDE grid of 2-bit cells held in a
// memory with one word per grid row. A clear word drops the per-row valid bits, so
// no clearing pass is needed after reset or clear. A read word goes through the
// memory read, then the output register, which waits while the output stalls, and
// returns one pixel. A paint word computes the clipped footprint and then reads and
// writes the row word of each grid row it covers; a leaf that misses the grid or is
// filtered by height writes no row. The single memory port is why each row takes a
// separate read and write. A finished pixel waits in the output register while the
// next word is taken.
module octree_leaf_to_occupancy_grid
    import olg_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            op,
    input  logic [KEY_W-1:0]      leaf_x,
    input  logic [KEY_W-1:0]      leaf_y,
    input  logic [3:0]            level,
    input  logic                  occupied,
    input  logic signed [Z_W-1:0] z_center,
    input  logic [7:0]            read_col,
    input  logic [7:0]            read_row,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            pixel,
    output logic [1:0]            cell_state
);

    olg_cmd_t cmd;
    olg_sts_t sts;

    olg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    olg_dp #(
        .GRID_SIDE (GRID_SIDE),
        .MAX_LEVEL (MAX_LEVEL)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .leaf_x     (leaf_x),
        .leaf_y     (leaf_y),
        .level      (level),
        .occupied   (occupied),
        .z_center   (z_center),
        .read_col   (read_col),
        .read_row   (read_row),
        .cmd        (cmd),
        .sts        (sts),
        .pixel      (pixel),
        .cell_state (cell_state)
    );

endmodule

@@ sim/octree_leaf_to_occupancy_grid_test.sv @@
// self-checking testbench for the octree leaf to occupancy grid projector
module octree_leaf_to_occupancy_grid_test;
    import olg_pkg::*;

    localparam int GRID_SIDE = GRID_SIDE_DEF;
    localparam int MAX_LEVEL = MAX_LEVEL_DEF;
    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASES = 6;
    // longest paint is a full-height leaf, with a read and a write for each row
    localparam int PAINT_TAIL = 2 + 2 * GRID_SIDE + 64;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef enum logic [1:0] {RX_FLOW, RX_CHOPPY, RX_CLOGGED} rx_mode_t;

    typedef struct {
        logic [1:0]         op;
        logic [15:0]        key_x;
        logic [15:0]        key_y;
        logic [3:0]         level;
        logic               occupied;
        logic signed [16:0] z;
        logic [7:0]         col;
        logic [7:0]         row;
    } grid_word_t;

    typedef struct {
        logic [7:0] pixel;
        logic [1:0] state;
    } pixel_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            op = '0;
    logic [KEY_W-1:0]      leaf_x = '0;
    logic [KEY_W-1:0]      leaf_y = '0;
    logic [3:0]            level = '0;
    logic                  occupied = 1'b0;
    logic signed [Z_W-1:0] z_center = '0;
    logic [7:0]            read_col = '0;
    logic [7:0]            read_row = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            pixel;
    logic [1:0]            cell_state;

    // mirror of the grid and its settings
    logic [1:0]         grid_cells [GRID_SIDE*GRID_SIDE];
    logic signed [16:0] lo_z = -17'sd65536;
    logic signed [16:0] hi_z = 17'sd65535;
    logic [15:0]        org_x = '0;
    logic [15:0]        org_y = '0;
    logic [8:0]         cols_cfg = 9'd256;
    logic [8:0]         rows_cfg = 9'd256;

    pixel_result_t pixel_queue[$];
    int            mismatch_count = 0;
    int            burst_left = 0;
    rx_mode_t      rx_mode = RX_FLOW;
    int            rx_left = 0;

    octree_leaf_to_occupancy_grid i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .leaf_x     (leaf_x),
        .leaf_y     (leaf_y),
        .level      (level),
        .occupied   (occupied),
        .z_center   (z_center),
        .read_col   (read_col),
        .read_row   (read_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel      (pixel),
        .cell_state (cell_state)
    );

    always #2 clk = ~clk;

    function automatic int fit_dim(input logic [8:0] v);
        if (v == 9'd0)
            return 1;
        if (int'(v) > GRID_SIDE)
            return GRID_SIDE;
        return int'(v);
    endfunction

    // update the grid mirror for one accepted word, queue the pixel a read returns
    function automatic void project_word(input grid_word_t w);
        int            lvl, side, x0, x1, y0, y1, cols, rows, j;
        logic [1:0]    st;
        pixel_result_t r;
        cols = fit_dim(cols_cfg);
        rows = fit_dim(rows_cfg);
        case (w.op)
            OP_CLEAR:
                foreach (grid_cells[i])
                    grid_cells[i] = CELL_UNKNOWN;
            OP_PAINT:
            begin
                lvl = (int'(w.level) > MAX_LEVEL) ? MAX_LEVEL : int'(w.level);
                side = 1 << lvl;
                if (!w.occupied || (w.z > lo_z && w.z < hi_z))
                begin
                    x0 = int'(w.key_x) - int'(org_x);
                    y0 = int'(w.key_y) - int'(org_y);
                    x1 = (x0 + side > cols) ? cols : x0 + side;
                    y1 = (y0 + side > rows) ? rows : y0 + side;
                    if (x0 < 0)
                        x0 = 0;
                    if (y0 < 0)
                        y0 = 0;
                    for (int y = y0; y < y1; y++)
                        for (int x = x0; x < x1; x++)
                            if (w.occupied)
                                grid_cells[y*GRID_SIDE + x] = CELL_OCC;
                            else if (grid_cells[y*GRID_SIDE + x] == CELL_UNKNOWN)
                                grid_cells[y*GRID_SIDE + x] = CELL_FREE;
                end
            end
            OP_READ:
            begin
                st = CELL_UNKNOWN;
                if (int'(w.col) < cols && int'(w.row) < rows)
                begin
                    // image rows run top down, grid rows bottom up
                    j = rows - 1 - int'(w.row);
                    st = grid_cells[j*GRID_SIDE + int'(w.col)];
                end
                r.state = st;
                r.pixel = (st == CELL_FREE) ? PIX_FREE : (st == CELL_OCC) ? PIX_OCC : PIX_UNKNOWN;
                pixel_queue.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic grid_word_t mk_op(input logic [1:0] code);
        grid_word_t w;
        w.op = code;
        w.key_x = 16'($urandom);
        w.key_y = 16'($urandom);
        w.level = 4'($urandom);
        w.occupied = 1'($urandom);
        w.z = 17'($urandom);
        w.col = 8'($urandom);
        w.row = 8'($urandom);
        return w;
    endfunction

    function automatic grid_word_t mk_paint(input logic [15:0] x, input logic [15:0] y,
                                            input logic [3:0] lvl, input logic occ,
                                            input logic signed [16:0] z);
        grid_word_t w;
        w = mk_op(OP_PAINT);
        w.key_x = x;
        w.key_y = y;
        w.level = lvl;
        w.occupied = occ;
        w.z = z;
        return w;
    endfunction

    function automatic grid_word_t mk_read(input logic [7:0] col, input logic [7:0] row);
        grid_word_t w;
        w = mk_op(OP_READ);
        w.col = col;
        w.row = row;
        return w;
    endfunction

    // offset into a small window near the grid origin, where paints and reads meet
    function automatic int near_cell(input int dim);
        return $urandom_range(0, ((dim < 24) ? dim : 24) - 1);
    endfunction

    function automatic grid_word_t random_word();
        grid_word_t w;
        int         pick, cols, rows;
        cols = fit_dim(cols_cfg);
        rows = fit_dim(rows_cfg);
        pick = $urandom_range(0, 99);
        if (pick < 2)
            w = mk_op(OP_CLEAR);
        else if (pick < 4)
            w = mk_op(OP_NONE);
        else if (pick < 52)
        begin
            w = mk_op(OP_PAINT);
            if ($urandom_range(0, 9) != 0)
            begin
                w.key_x = org_x + 16'(near_cell(cols)) + 16'($urandom_range(0, 3)) - 16'd2;
                w.key_y = org_y + 16'(near_cell(rows)) + 16'($urandom_range(0, 3)) - 16'd2;
                if ($urandom_range(0, 15) != 0)
                    w.level = 4'($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    1: w.z = lo_z + 17'($urandom_range(0, 4)) - 17'd2;
                    2: w.z = hi_z + 17'($urandom_range(0, 4)) - 17'd2;
                    3: w.z = 17'((int'(lo_z) + int'(hi_z)) / 2);
                    default: w.z = 17'($urandom);
                endcase
            end
        end
        else
        begin
            w = mk_op(OP_READ);
            if ($urandom_range(0, 4) != 0)
            begin
                w.col = 8'(near_cell(cols));
                w.row = 8'(rows - 1 - near_cell(rows));
            end
        end
        return w;
    endfunction

    // sender: bursts of words with random gaps between them
    task automatic send_word(input grid_word_t w);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= w.op;
        leaf_x <= w.key_x;
        leaf_y <= w.key_y;
        level <= w.level;
        occupied <= w.occupied;
        z_center <= w.z;
        read_col <= w.col;
        read_row <= w.row;
        do
            @(posedge clk);
        while (in_stall);
        project_word(w);
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_grid_config(input logic signed [16:0] lo, input logic signed [16:0] hi,
                                   input logic [15:0] ox, input logic [15:0] oy,
                                   input logic [8:0] w, input logic [8:0] h);
        in_valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        // a paint leaves no result, so let the longest one finish
        repeat (PAINT_TAIL) @(posedge clk);
        cfg_put(CFG_MIN_Z, lo);
        cfg_put(CFG_MAX_Z, hi);
        cfg_put(CFG_ORIGIN_X, 17'(ox));
        cfg_put(CFG_ORIGIN_Y, 17'(oy));
        cfg_put(CFG_WIDTH, 17'(w));
        cfg_put(CFG_HEIGHT, 17'(h));
        cfg_we <= 1'b0;
        lo_z = lo;
        hi_z = hi;
        org_x = ox;
        org_y = oy;
        cols_cfg = w;
        rows_cfg = h;
    endtask

    // reset settings: row flip, level clamp, height filter at the extremes, edges
    task automatic test_default_grid();
        send_word(mk_read(8'd0, 8'd0));
        send_word(mk_paint(16'd0, 16'd0, 4'd0, 1'b1, 17'sd0));
        send_word(mk_read(8'd0, 8'd255));
        send_word(mk_paint(16'd0, 16'd0, 4'd15, 1'b0, -17'sd65536));
        send_word(mk_read(8'd255, 8'd0));
        send_word(mk_paint(16'hFFFF, 16'hFFFF, 4'd2, 1'b1, 17'sd0));
        send_word(mk_paint(16'd8, 16'd8, 4'd3, 1'b1, -17'sd65536));
        send_word(mk_paint(16'd16, 16'd16, 4'd3, 1'b1, 17'sd65535));
        send_word(mk_read(8'd8, 8'd247));
        send_word(mk_paint(16'd255, 16'd255, 4'd1, 1'b1, 17'sd1));
        send_word(mk_read(8'd255, 8'd0));
        send_word(mk_op(OP_NONE));
        send_word(mk_op(OP_CLEAR));
        send_word(mk_read(8'd255, 8'd0));
        send_word(mk_paint(16'd3, 16'd5, 4'd0, 1'b0, 17'sd0));
        send_word(mk_paint(16'd3, 16'd5, 4'd0, 1'b1, 17'sd100));
        send_word(mk_read(8'd3, 8'd250));
    endtask

    // clamped grid sizes, keys below the origin, reads outside the grid
    task automatic test_clamped_grid();
        set_grid_config(-17'sd1, 17'sd1, 16'd100, 16'd200, 9'd0, 9'd300);
        send_word(mk_paint(16'd96, 16'd196, 4'd3, 1'b1, 17'sd0));
        send_word(mk_read(8'd0, 8'd255));
        send_word(mk_read(8'd1, 8'd255));
        send_word(mk_read(8'd0, 8'd251));
        send_word(mk_paint(16'd100, 16'd210, 4'd0, 1'b1, 17'sd1));
        send_word(mk_paint(16'd99, 16'd210, 4'd0, 1'b0, 17'sd0));
        send_word(mk_read(8'd0, 8'd245));
        set_grid_config(17'sd65535, -17'sd65536, 16'h8000, 16'h8000, 9'd511, 9'd0);
        send_word(mk_paint(16'h8000, 16'h8000, 4'd8, 1'b0, 17'sd0));
        send_word(mk_read(8'd255, 8'd0));
        send_word(mk_read(8'd0, 8'd1));
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_grid_config(-17'sd65536, 17'sd65535, 16'd0, 16'd0, 9'd256, 9'd256);
                1: set_grid_config(-17'sd100, 17'sd100, 16'($urandom), 16'($urandom),
                                   9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)));
                2: set_grid_config(17'sd65535, -17'sd65536, 16'hFFFF, 16'hFFFF, 9'd1, 9'd1);
                3: set_grid_config(17'($urandom), 17'($urandom), 16'($urandom), 16'($urandom),
                                   9'd0, 9'd511);
                4: set_grid_config(-17'sd2, 17'sd2, 16'($urandom), 16'($urandom),
                                   9'($urandom_range(257, 511)), 9'($urandom_range(1, 40)));
                default: set_grid_config(17'($urandom), 17'($urandom), 16'($urandom),
                                         16'($urandom), 9'($urandom), 9'($urandom));
            endcase
            repeat (RANDOM_ITEMS / PHASES)
                send_word(random_word());
        end
    endtask

    // receiver stall pattern: free flowing, choppy, or mostly blocked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_mode <= RX_FLOW;
            rx_left <= 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 2));
                rx_left <= $urandom_range(50, 400);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                RX_FLOW:    out_stall <= 1'b0;
                RX_CHOPPY:  out_stall <= ($urandom_range(0, 1) == 1);
                default:    out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_pixel
        pixel_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_queue.size() == 0)
            begin
                $display("%0t unexpected word: pixel %0d cell_state %0d", $time, pixel,
                         cell_state);
                mismatch_count++;
            end
            else
            begin
                e = pixel_queue.pop_front();
                if (pixel !== e.pixel)
                begin
                    $display("%0t pixel mismatch: expected %0d actual %0d", $time, e.pixel,
                             pixel);
                    mismatch_count++;
                end
                if (cell_state !== e.state)
                begin
                    $display("%0t cell_state mismatch: expected %0d actual %0d", $time,
                             e.state, cell_state);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        foreach (grid_cells[i])
            grid_cells[i] = CELL_UNKNOWN;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_grid();
        test_clamped_grid();
        test_random_phases();
        in_valid <= 1'b0;
        wait_drained();
        repeat (PAINT_TAIL) @(posedge clk);
        if (pixel_queue.size() != 0)
        begin
            $display("%0t %0d pixel words never arrived", $time, pixel_queue.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("%0t timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
